@@ design/edm_pkg.sv @@
// Shared widths, codes and the sequencer state type for the distance matrix block.
`default_nettype none
package edm_pkg;

  localparam int COORD_IN_W = 16;
  localparam int ROW_W      = 6;
  localparam int DIST_W     = 17;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_ROW  = 1'b1;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_ROWCAP = 10'b00_0000_0010,
    ST_COLRD  = 10'b00_0000_0100,
    ST_DIFF   = 10'b00_0000_1000,
    ST_MULX   = 10'b00_0001_0000,
    ST_MULY   = 10'b00_0010_0000,
    ST_SUM    = 10'b00_0100_0000,
    ST_ROOT   = 10'b00_1000_0000,
    ST_RND    = 10'b01_0000_0000,
    ST_EMIT   = 10'b10_0000_0000
  } edm_state_t;

endpackage
`default_nettype wire

@@ design/edm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module edm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ design/euclid_distance_matrix.sv @@
// A bad row request's word is valid the cycle after acceptance.
// A row of N cities gives one word per column; its pace is set by the one-bit-per-cycle square root
// step shared by every column.
// Input: one word at a time; after a row request the input stalls until the row's last word is taken.
// Reset (rst_n, synchronous): empties the city list and clears the sticky overflow flag;
// coordinate storage is not cleared.
`default_nettype none
module euclid_distance_matrix #(
  parameter int MAX_CITIES = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_kind,
  input  wire logic                                in_first_city,
  input  wire logic signed [edm_pkg::COORD_IN_W-1:0] in_coord_x,
  input  wire logic signed [edm_pkg::COORD_IN_W-1:0] in_coord_y,
  input  wire logic        [edm_pkg::ROW_W-1:0]      in_row_index,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic             [edm_pkg::DIST_W-1:0]     out_distance,
  output logic             [edm_pkg::ROW_W-1:0]      out_column_index,
  output logic                                     out_last,
  output logic                                     out_bad_row,
  output logic                                     out_overflowed
);

  import edm_pkg::*;

  localparam int CW   = (COORD_BITS < COORD_IN_W) ? COORD_BITS : COORD_IN_W;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * CW;
  localparam int RW   = CW + 1;
  localparam int SP   = 2 * RW;
  localparam int AW   = $clog2(MAX_CITIES);
  localparam int CNTW = $clog2(MAX_CITIES + 1);
  localparam int STW  = $clog2(RW);

  edm_state_t state_r, state_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            overflow_r, overflow_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [AW-1:0]          col_r, col_nxt;
  logic [CW-1:0]          xr_r, xr_nxt, yr_r, yr_nxt;
  logic signed [DW-1:0]   dx_r, dx_nxt, dy_r, dy_nxt;
  logic [PW-1:0]          prod_r, prod_nxt, acc_r, acc_nxt;
  logic [SP-1:0]          s_r, s_nxt;
  logic [RW-1:0]          root_r, root_nxt;
  logic [RW:0]            rem_r, rem_nxt;
  logic [STW-1:0]         step_r, step_nxt;
  logic [DIST_W-1:0]      dist_r, dist_nxt;
  logic [ROW_W-1:0]       ocol_r, ocol_nxt;
  logic                   last_r, last_nxt, bad_r, bad_nxt, oflow_r, oflow_nxt;

  logic                   in_acc, out_acc;
  logic [CNTW-1:0]        count_eff;
  logic                   room;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [CW-1:0]          x_rdata, y_rdata;
  logic                   row_bad;
  logic                   col_last;

  logic signed [DW-1:0]   mul_a;
  logic signed [2*DW-1:0] mul_p;
  logic [RW+2:0]          sq_t, sq_d, sq_diff;
  logic                   sq_ge;
  logic                   round_up;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;

  assign count_eff = in_first_city ? '0 : count_r;
  assign room      = count_eff < CNTW'(MAX_CITIES);
  assign ram_we    = in_acc && (in_kind == KIND_LOAD) && room;
  assign ram_waddr = count_eff[AW-1:0];
  assign ram_raddr = (state_r == ST_IDLE) ? in_row_index[AW-1:0] : col_r;
  assign row_bad   = {1'b0, in_row_index} >= (ROW_W+1)'(count_r);
  assign col_last  = (CNTW'(col_r) + CNTW'(1)) == count_r;

  edm_ram #(.WIDTH(CW), .DEPTH(MAX_CITIES)) u_x_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_coord_x[CW-1:0]),
    .raddr (ram_raddr),
    .rdata (x_rdata)
  );

  edm_ram #(.WIDTH(CW), .DEPTH(MAX_CITIES)) u_y_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_coord_y[CW-1:0]),
    .raddr (ram_raddr),
    .rdata (y_rdata)
  );

  // shared squarer: dx in MULX, dy in MULY
  assign mul_a = (state_r == ST_MULY) ? dy_r : dx_r;
  assign mul_p = mul_a * mul_a;

  // one restoring square root step: bring down two bits, try subtracting 4*root+1
  assign sq_t    = {rem_r, s_r[SP-1:SP-2]};
  assign sq_d    = {1'b0, root_r, 2'b01};
  assign sq_ge   = sq_t >= sq_d;
  assign sq_diff = sq_t - sq_d;

  // remainder is s - r*r, so this is the round-to-nearest test
  assign round_up = rem_r > {1'b0, root_r};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    overflow_nxt  = overflow_r;
    out_valid_nxt = out_valid_r;
    col_nxt       = col_r;
    xr_nxt        = xr_r;
    yr_nxt        = yr_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    s_nxt         = s_r;
    root_nxt      = root_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    dist_nxt      = dist_r;
    ocol_nxt      = ocol_r;
    last_nxt      = last_r;
    bad_nxt       = bad_r;
    oflow_nxt     = oflow_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == KIND_LOAD) begin
            if (room) begin
              count_nxt = count_eff + CNTW'(1);
            end else begin
              count_nxt    = count_eff;
              overflow_nxt = 1'b1;
            end
          end else if (row_bad) begin
            dist_nxt      = '0;
            ocol_nxt      = '0;
            last_nxt      = 1'b1;
            bad_nxt       = 1'b1;
            oflow_nxt     = overflow_r;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_EMIT;
          end else begin
            col_nxt   = '0;
            state_nxt = ST_ROWCAP;
          end
        end
      end
      ST_ROWCAP: begin
        // row city arrives; column 0 read is issued this cycle
        xr_nxt    = x_rdata;
        yr_nxt    = y_rdata;
        state_nxt = ST_DIFF;
      end
      ST_COLRD: begin
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        dx_nxt    = $signed({xr_r[CW-1], xr_r}) - $signed({x_rdata[CW-1], x_rdata});
        dy_nxt    = $signed({yr_r[CW-1], yr_r}) - $signed({y_rdata[CW-1], y_rdata});
        state_nxt = ST_MULX;
      end
      ST_MULX: begin
        prod_nxt  = mul_p[PW-1:0];
        state_nxt = ST_MULY;
      end
      ST_MULY: begin
        acc_nxt   = prod_r;
        prod_nxt  = mul_p[PW-1:0];
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        s_nxt     = SP'({1'b0, acc_r} + {1'b0, prod_r});
        root_nxt  = '0;
        rem_nxt   = '0;
        step_nxt  = STW'(RW - 1);
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        s_nxt    = s_r << 2;
        rem_nxt  = sq_ge ? sq_diff[RW:0] : sq_t[RW:0];
        root_nxt = {root_r[RW-2:0], sq_ge};
        step_nxt = step_r - STW'(1);
        if (step_r == '0) begin
          state_nxt = ST_RND;
        end
      end
      ST_RND: begin
        dist_nxt      = DIST_W'((RW+1)'(root_r) + (RW+1)'(round_up));
        ocol_nxt      = ROW_W'(col_r);
        last_nxt      = col_last;
        bad_nxt       = 1'b0;
        oflow_nxt     = overflow_r;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            col_nxt   = col_r + AW'(1);
            state_nxt = ST_COLRD;
          end
        end
      end
      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r  <= col_nxt;
    xr_r   <= xr_nxt;
    yr_r   <= yr_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    s_r    <= s_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    dist_r <= dist_nxt;
    ocol_r <= ocol_nxt;
    last_r <= last_nxt;
    bad_r  <= bad_nxt;
    oflow_r <= oflow_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_distance     = dist_r;
  assign out_column_index = ocol_r;
  assign out_last         = last_r;
  assign out_bad_row      = bad_r;
  assign out_overflowed   = oflow_r;

  a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_EMIT)
    else $error("result word valid outside emit state");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(MAX_CITIES))
    else $error("city count above capacity");

  a_full_load_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == KIND_LOAD && !in_first_city && count_r == CNTW'(MAX_CITIES))
    |=> overflow_r && $stable(count_r))
    else $error("load into full list did not set overflow");

  a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && bad_r) |-> (last_r && dist_r == '0 && ocol_r == '0))
    else $error("bad row word malformed");

  a_next_column: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !last_r) |=> state_r == ST_COLRD && col_r == $past(col_r) + AW'(1))
    else $error("row did not advance to next column");

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for euclid_distance_matrix: loads, rows, overflow, backpressure.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import edm_pkg::*;

  localparam int CITY_CAP    = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 200;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [DIST_W-1:0] DIST_SAT = '1;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [ROW_W-1:0]  column_index;
    logic              last;
    logic              bad_row;
    logic              overflowed;
  } dist_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         in_kind = KIND_LOAD;
  logic                         in_first_city = 1'b0;
  logic signed [COORD_IN_W-1:0] in_coord_x = '0;
  logic signed [COORD_IN_W-1:0] in_coord_y = '0;
  logic        [ROW_W-1:0]      in_row_index = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic        [DIST_W-1:0]     out_distance;
  logic        [ROW_W-1:0]      out_column_index;
  logic                         out_last;
  logic                         out_bad_row;
  logic                         out_overflowed;

  // predicted state of the city list
  logic signed [COORD_IN_W-1:0] city_x [CITY_CAP];
  logic signed [COORD_IN_W-1:0] city_y [CITY_CAP];
  int   city_count = 0;
  logic overflow_seen = 1'b0;

  dist_word_t pending_words[$];
  dist_word_t got_word, want_word;
  int   mismatches = 0;
  int   cycle_count = 0;
  logic no_idle = 1'b0;
  logic hold_req = 1'b0;
  int   held = 0;

  euclid_distance_matrix dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_first_city    (in_first_city),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_row_index     (in_row_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_distance     (out_distance),
    .out_column_index (out_column_index),
    .out_last         (out_last),
    .out_bad_row      (out_bad_row),
    .out_overflowed   (out_overflowed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // rounded distance: exact integer sqrt, then round up when s - r*r > r
  function automatic logic [DIST_W-1:0] city_distance(int a, int b);
    longint dx, dy;
    longint unsigned sq, root, trial;
    int bitpos;
    dx = longint'(city_x[a]) - longint'(city_x[b]);
    dy = longint'(city_y[a]) - longint'(city_y[b]);
    sq = longint'(dx * dx) + longint'(dy * dy);
    root = 0;
    for (bitpos = 17; bitpos >= 0; bitpos--) begin
      trial = root | (64'd1 << bitpos);
      if (trial * trial <= sq) root = trial;
    end
    if (sq - root * root > root) root = root + 1;
    if (root > longint'(DIST_SAT)) root = longint'(DIST_SAT);
    return root[DIST_W-1:0];
  endfunction

  function automatic void queue_expected(dist_word_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic void predict_distances(logic kind, logic first,
                                            logic signed [COORD_IN_W-1:0] x,
                                            logic signed [COORD_IN_W-1:0] y,
                                            logic [ROW_W-1:0] row);
    dist_word_t w;
    int col;
    if (kind == KIND_LOAD) begin
      if (first) city_count = 0;
      if (city_count < CITY_CAP) begin
        city_x[city_count] = x;
        city_y[city_count] = y;
        city_count++;
      end else begin
        overflow_seen = 1'b1;
      end
    end else if (int'(row) >= city_count) begin
      w.distance     = '0;
      w.column_index = '0;
      w.last         = 1'b1;
      w.bad_row      = 1'b1;
      w.overflowed   = overflow_seen;
      queue_expected(w);
    end else begin
      for (col = 0; col < city_count; col++) begin
        w.distance     = city_distance(int'(row), col);
        w.column_index = col[ROW_W-1:0];
        w.last         = (col == city_count - 1);
        w.bad_row      = 1'b0;
        w.overflowed   = overflow_seen;
        queue_expected(w);
      end
    end
  endfunction

  task automatic send_word(logic kind, logic first, logic signed [COORD_IN_W-1:0] x,
                           logic signed [COORD_IN_W-1:0] y, logic [ROW_W-1:0] row);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_first_city <= first;
    in_coord_x    <= x;
    in_coord_y    <= y;
    in_row_index  <= row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_distances(kind, first, x, y, row);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [COORD_IN_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1, 2, 3: return 16'($urandom_range(0, 16)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && held < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      held      <= held + 1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < 34);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_word.distance     = out_distance;
      got_word.column_index = out_column_index;
      got_word.last         = out_last;
      got_word.bad_row      = out_bad_row;
      got_word.overflowed   = out_overflowed;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: dist %0d col %0d last %0b bad %0b ovf %0b",
                   got_word.distance, got_word.column_index, got_word.last,
                   got_word.bad_row, got_word.overflowed);
      end else begin
        want_word = pending_words.pop_front();
        if (got_word.distance != want_word.distance ||
            got_word.column_index != want_word.column_index ||
            got_word.last != want_word.last ||
            got_word.bad_row != want_word.bad_row ||
            got_word.overflowed != want_word.overflowed) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("word mismatch: exp dist %0d col %0d last %0b bad %0b ovf %0b",
                     want_word.distance, want_word.column_index, want_word.last,
                     want_word.bad_row, want_word.overflowed);
            $display("               got dist %0d col %0d last %0b bad %0b ovf %0b",
                     got_word.distance, got_word.column_index, got_word.last,
                     got_word.bad_row, got_word.overflowed);
          end
        end
      end
    end
  end

  task automatic test_empty_rows();
    send_word(KIND_ROW, 1'b0, 16'sd0, 16'sd0, 6'd0);
    send_word(KIND_ROW, 1'b1, 16'sh7FFF, 16'sh8000, 6'd63);
  endtask

  task automatic test_extreme_coords();
    send_word(KIND_LOAD, 1'b1, 16'sh8000, 16'sh8000, 6'd63);
    send_word(KIND_LOAD, 1'b0, 16'sh7FFF, 16'sh7FFF, 6'd0);
    send_word(KIND_LOAD, 1'b0, 16'sh8000, 16'sh7FFF, 6'd21);
    send_word(KIND_LOAD, 1'b0, 16'sh7FFF, 16'sh8000, 6'd42);
    send_word(KIND_LOAD, 1'b0, 16'sd0, 16'sd0, 6'd0);
    send_word(KIND_ROW, 1'b0, 16'sd0, 16'sd0, 6'd0);
    send_word(KIND_ROW, 1'b1, 16'sh5555, 16'shAAAA, 6'd1);
    send_word(KIND_ROW, 1'b0, 16'sd0, 16'sd0, 6'd4);
    send_word(KIND_ROW, 1'b0, 16'sd0, 16'sd0, 6'd5);   // one past the end
  endtask

  // sqrt(2) rounds down, sqrt(5) down, sqrt(8) up, 5 and 10 exact
  task automatic test_rounding();
    send_word(KIND_LOAD, 1'b1, 16'sd0, 16'sd0, 6'd0);
    send_word(KIND_LOAD, 1'b0, 16'sd1, 16'sd1, 6'd0);
    send_word(KIND_LOAD, 1'b0, 16'sd2, 16'sd2, 6'd0);
    send_word(KIND_LOAD, 1'b0, 16'sd1, 16'sd2, 6'd0);
    send_word(KIND_LOAD, 1'b0, 16'sd3, 16'sd4, 6'd0);
    send_word(KIND_LOAD, 1'b0, -16'sd3, -16'sd4, 6'd0);
    send_word(KIND_ROW, 1'b0, 16'sd0, 16'sd0, 6'd0);
    send_word(KIND_ROW, 1'b0, 16'sd0, 16'sd0, 6'd5);
  endtask

  // output held off while the sender keeps offering words, then a full drain
  task automatic test_backpressure();
    int i;
    send_word(KIND_LOAD, 1'b1, rand_coord(), rand_coord(), 6'($urandom));
    for (i = 1; i < 12; i++)
      send_word(KIND_LOAD, 1'b0, rand_coord(), rand_coord(), 6'($urandom));
    hold_req = 1'b1;
    send_word(KIND_ROW, 1'b0, rand_coord(), rand_coord(), 6'd3);
    send_word(KIND_ROW, 1'b0, rand_coord(), rand_coord(), 6'd11);
    send_word(KIND_LOAD, 1'b0, rand_coord(), rand_coord(), 6'($urandom));
    send_word(KIND_ROW, 1'b1, rand_coord(), rand_coord(), 6'd12);
    wait_for_results();
    send_word(KIND_ROW, 1'b0, rand_coord(), rand_coord(), 6'd0);
  endtask

  task automatic test_random_lists(int n_words);
    int sent, len, i, rows;
    logic [ROW_W-1:0] row;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 99) < 80) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 63) : $urandom_range(1, 10);
        send_word(KIND_LOAD, 1'b1, rand_coord(), rand_coord(), 6'($urandom));
        for (i = 1; i < len; i++)
          send_word(KIND_LOAD, 1'b0, rand_coord(), rand_coord(), 6'($urandom));
        rows = $urandom_range(1, 3);
        for (i = 0; i < rows; i++) begin
          row = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, len - 1)) : 6'($urandom);
          send_word(KIND_ROW, 1'($urandom), rand_coord(), rand_coord(), row);
        end
        sent += len + rows;
      end else if ($urandom_range(0, 1)) begin
        // stray append; keep below capacity until the overflow test
        send_word(KIND_LOAD, (city_count >= CITY_CAP - 1) ? 1'b1 : 1'($urandom),
                  rand_coord(), rand_coord(), 6'($urandom));
        sent++;
      end else begin
        send_word(KIND_ROW, 1'($urandom), rand_coord(), rand_coord(), 6'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_no_idle_stretch();
    no_idle = 1'b1;
    test_random_lists(20);
    no_idle = 1'b0;
  endtask

  task automatic test_overflow();
    int i;
    send_word(KIND_LOAD, 1'b1, rand_coord(), rand_coord(), 6'($urandom));
    for (i = 1; i < CITY_CAP; i++)
      send_word(KIND_LOAD, 1'b0, rand_coord(), rand_coord(), 6'($urandom));
    send_word(KIND_LOAD, 1'b0, rand_coord(), rand_coord(), 6'($urandom));  // dropped
    send_word(KIND_LOAD, 1'b0, 16'sh7FFF, 16'sh8000, 6'($urandom));        // dropped
    send_word(KIND_ROW, 1'b0, rand_coord(), rand_coord(), 6'd63);
    send_word(KIND_ROW, 1'b0, rand_coord(), rand_coord(), 6'd0);
    // first_city on a full list restarts it; the sticky flag stays set
    send_word(KIND_LOAD, 1'b1, rand_coord(), rand_coord(), 6'($urandom));
    send_word(KIND_ROW, 1'b0, rand_coord(), rand_coord(), 6'd0);
    send_word(KIND_ROW, 1'b0, rand_coord(), rand_coord(), 6'd1);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_rows();
    test_extreme_coords();
    test_rounding();
    test_backpressure();
    test_random_lists(24);
    test_no_idle_stretch();
    test_random_lists(12);
    test_overflow();
    test_random_lists(6);
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
